[hdl/apgq_pkg.sv]
// Package for the accumulated pixel gamma quantizer.
// Widths, stage counts, the gamma scale constant and the per-channel flag type.
// No dependencies.
`timescale 1ns / 1ps

package apgq_pkg;

    // Default fraction bits of the incoming Q-format sums
    localparam int SUM_FRAC_BITS_DEF = 16;

    // Field widths
    localparam int SUM_W   = 32;
    localparam int COUNT_W = 16;
    localparam int AVG_W   = 16;    // average fraction bits (1.0 = 2^AVG_W)
    localparam int ROOT_W  = 16;    // square root fraction bits
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = 32;

    // Pipeline depth: prep + one stage per quotient bit, one per root bit, two for scaling
    localparam int DIV_STAGES   = AVG_W + 1;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int SCALE_STAGES = 2;
    localparam int NUM_STAGES   = DIV_STAGES + SQRT_STAGES + SCALE_STAGES;

    // 255.99 as 65533 / 2^8, applied to a 16-fraction-bit root
    localparam logic [15:0] GAMMA_SCALE = 16'd65533;

    // Per-channel override flags that ride along the pipeline
    typedef struct packed {
        logic neg;   // sum was negative: result forced to 0
        logic sat;   // average reached 1.0: result forced to full scale
    } apgq_flags_t;

endpackage

[hdl/apgq_div.sv]
// Pipelined restoring divider for one channel: average = sum / sample count.
// One quotient bit per stage after a prep stage; saturation detected up front.
// Depends on apgq_pkg.
`timescale 1ns / 1ps

module apgq_div #(
    parameter int SUM_FRAC_BITS = apgq_pkg::SUM_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             adv,
    input  logic signed [apgq_pkg::SUM_W-1:0] sum,
    input  logic [apgq_pkg::COUNT_W-1:0]     count,
    output logic [apgq_pkg::AVG_W-1:0]       quot,
    output apgq_pkg::apgq_flags_t            flags
);

    localparam int AVG_W   = apgq_pkg::AVG_W;
    localparam int COUNT_W = apgq_pkg::COUNT_W;
    localparam int MAG_W   = apgq_pkg::SUM_W - 1;
    localparam int UP      = (SUM_FRAC_BITS < AVG_W) ? (AVG_W - SUM_FRAC_BITS) : 0;
    localparam int DN      = (SUM_FRAC_BITS > AVG_W) ? (SUM_FRAC_BITS - AVG_W) : 0;
    localparam int DIV_W   = MAG_W + UP;
    localparam int SAT_W   = COUNT_W + AVG_W;
    localparam int REM_W   = (DIV_W > SAT_W) ? DIV_W : SAT_W;

    logic [REM_W-1:0]       rem_reg [0:AVG_W-1];
    logic [COUNT_W-1:0]     cnt_reg [0:AVG_W-1];
    logic [AVG_W-1:0]       q_reg   [0:AVG_W];
    apgq_pkg::apgq_flags_t  flg_reg [0:AVG_W];

    logic [MAG_W-1:0]       mag;
    logic [REM_W-1:0]       dvd;
    logic [COUNT_W-1:0]     cnt;
    apgq_pkg::apgq_flags_t  flg;

    // Prep: align dividend to the average's fraction, clamp count, check saturation
    always_comb
    begin
        mag     = sum[MAG_W-1:0];
        dvd     = (REM_W'(mag) << UP) >> DN;
        cnt     = (count == '0) ? COUNT_W'(1) : count;
        flg.neg = sum[MAG_W];
        flg.sat = dvd >= (REM_W'(cnt) << AVG_W);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= dvd;
            cnt_reg[0] <= cnt;
            q_reg[0]   <= '0;
            flg_reg[0] <= flg;
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar k = 1; k <= AVG_W; k++)
    begin : g_bit
        localparam int B = AVG_W - k;

        logic [REM_W-1:0] trial;
        logic             ge;
        logic [AVG_W-1:0] q_next;

        always_comb
        begin
            trial     = REM_W'(cnt_reg[k-1]) << B;
            ge        = rem_reg[k-1] >= trial;
            q_next    = q_reg[k-1];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[k]   <= q_next;
                flg_reg[k] <= flg_reg[k-1];
            end
        end

        // remainder and divisor are not needed past the last bit
        if (k < AVG_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    cnt_reg[k] <= cnt_reg[k-1];
                end
            end
        end
    end

    assign quot  = q_reg[AVG_W];
    assign flags = flg_reg[AVG_W];

endmodule

[hdl/apgq_sqrt.sv]
// Pipelined bit-by-bit square root for one channel: root = floor(sqrt(avg * 2^16)).
// One root bit per stage, MSB first, remainder kept as value minus root squared.
// Depends on apgq_pkg.
`timescale 1ns / 1ps

module apgq_sqrt (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [apgq_pkg::AVG_W-1:0]  avg,
    input  apgq_pkg::apgq_flags_t       flags_in,
    output logic [apgq_pkg::ROOT_W-1:0] root,
    output apgq_pkg::apgq_flags_t       flags
);

    localparam int ROOT_W = apgq_pkg::ROOT_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int TRY_W  = RAD_W + 2;

    logic [RAD_W-1:0]       rem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0]      root_reg [0:ROOT_W-1];
    apgq_pkg::apgq_flags_t  flg_reg  [0:ROOT_W-1];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_bit
        localparam int B = ROOT_W - 1 - j;

        logic [RAD_W-1:0]      rem_prev;
        logic [ROOT_W-1:0]     root_prev;
        apgq_pkg::apgq_flags_t flg_prev;
        logic [TRY_W-1:0]      trial;
        logic                  ge;
        logic [ROOT_W-1:0]     root_next;

        // First stage starts from the radicand itself
        if (j == 0)
        begin : g_first
            assign rem_prev  = RAD_W'(avg) << ROOT_W;
            assign root_prev = '0;
            assign flg_prev  = flags_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign flg_prev  = flg_reg[j-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        always_comb
        begin
            trial        = (TRY_W'(root_prev) << (B + 1)) + (TRY_W'(1) << (2 * B));
            ge           = TRY_W'(rem_prev) >= trial;
            root_next    = root_prev;
            root_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[j] <= root_next;
                flg_reg[j]  <= flg_prev;
            end
        end

        if (j < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[j] <= ge ? RAD_W'(TRY_W'(rem_prev) - trial) : rem_prev;
                end
            end
        end
    end

    assign root  = root_reg[ROOT_W-1];
    assign flags = flg_reg[ROOT_W-1];

endmodule

[hdl/apgq_scale.sv]
// Output scaling for one channel: byte = floor(root * 65533 / 2^24), with overrides.
// Multiply stage, then byte select / force stage.
// Depends on apgq_pkg.
`timescale 1ns / 1ps

module apgq_scale (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [apgq_pkg::ROOT_W-1:0] root,
    input  apgq_pkg::apgq_flags_t       flags_in,
    output logic [apgq_pkg::BYTE_W-1:0] chan_byte
);

    localparam int PROD_W = apgq_pkg::PROD_W;
    localparam int BYTE_W = apgq_pkg::BYTE_W;

    logic [PROD_W-1:0]     prod_reg;
    apgq_pkg::apgq_flags_t flg_reg;
    logic [BYTE_W-1:0]     chan_byte_reg;
    logic [BYTE_W-1:0]     chan_byte_next;

    // Stage 1: constant multiply
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= PROD_W'(root) * PROD_W'(apgq_pkg::GAMMA_SCALE);
            flg_reg  <= flags_in;
        end
    end

    // Stage 2: take top byte; negative wins over saturation
    always_comb
    begin
        if (flg_reg.neg)
            chan_byte_next = '0;
        else if (flg_reg.sat)
            chan_byte_next = '1;
        else
            chan_byte_next = prod_reg[PROD_W-1 -: BYTE_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chan_byte_reg <= chan_byte_next;
        end
    end

    assign chan_byte = chan_byte_reg;

endmodule

[hdl/accumulated_pixel_gamma_quantizer_unit.sv]
// Top level of the accumulated pixel gamma quantizer: sample-count register,
// valid/stall pipeline control, three channel datapaths and the output skid.
// Depends on apgq_pkg, apgq_div, apgq_sqrt, apgq_scale.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   pixel   | in        | pixel_valid / pixel_stall  | red_sum, green_sum, blue_sum, end_of_frame
//   result  | out       | result_valid / result_stall| red_byte, green_byte, blue_byte, frame_done
//   cfg     | in        | cfg_valid / cfg_ready      | cfg_data (sample count)
//
// One pixel word per cycle while pixel_stall is low; from acceptance to result_valid a word passes
// 17 divider stages (prep + 16 quotient bits), 16 root stages, 2 scaling stages and the output register.
// The pipeline moves as one; a two-entry output (register + skid) absorbs a stall,
// so pixel_stall only rises when both hold a word. pixel_stall is a register.
// Reset clears valid bits, the skid and loads a sample count of one.
`timescale 1ns / 1ps

module accumulated_pixel_gamma_quantizer_unit #(
    parameter int SUM_FRAC_BITS = apgq_pkg::SUM_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [apgq_pkg::COUNT_W-1:0]       cfg_data,

    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic signed [apgq_pkg::SUM_W-1:0]  red_sum,
    input  logic signed [apgq_pkg::SUM_W-1:0]  green_sum,
    input  logic signed [apgq_pkg::SUM_W-1:0]  blue_sum,
    input  logic                               end_of_frame,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [apgq_pkg::BYTE_W-1:0]        red_byte,
    output logic [apgq_pkg::BYTE_W-1:0]        green_byte,
    output logic [apgq_pkg::BYTE_W-1:0]        blue_byte,
    output logic                               frame_done
);

    localparam int NUM_STAGES = apgq_pkg::NUM_STAGES;
    localparam int NUM_CHAN   = 3;
    localparam int BYTE_W     = apgq_pkg::BYTE_W;
    localparam int COUNT_W    = apgq_pkg::COUNT_W;

    logic [COUNT_W-1:0]    sample_count_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] eof_reg;
    logic                  adv;
    logic                  leaving;
    logic                  take;

    logic                  result_valid_reg;
    logic [BYTE_W-1:0]     result_byte_reg [0:NUM_CHAN-1];
    logic                  result_eof_reg;
    logic                  skid_full_reg;
    logic [BYTE_W-1:0]     skid_byte_reg   [0:NUM_CHAN-1];
    logic                  skid_eof_reg;

    logic signed [apgq_pkg::SUM_W-1:0] sum_w  [0:NUM_CHAN-1];
    logic [BYTE_W-1:0]                 byte_w [0:NUM_CHAN-1];

    // Sample count register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_count_reg <= COUNT_W'(1);
        else if (cfg_valid)
            sample_count_reg <= cfg_data;
    end

    // Pipeline control: whole pipe advances while the skid has room
    assign adv         = !skid_full_reg;
    assign pixel_stall = skid_full_reg;
    assign leaving     = adv && valid_reg[NUM_STAGES-1];
    assign take        = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NUM_STAGES-2:0], pixel_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            eof_reg <= {eof_reg[NUM_STAGES-2:0], end_of_frame};
    end

    // Channel datapaths
    assign sum_w[0] = red_sum;
    assign sum_w[1] = green_sum;
    assign sum_w[2] = blue_sum;

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_chan
        logic [apgq_pkg::AVG_W-1:0]  quot;
        apgq_pkg::apgq_flags_t       div_flags;
        logic [apgq_pkg::ROOT_W-1:0] root;
        apgq_pkg::apgq_flags_t       root_flags;

        apgq_div #(
            .SUM_FRAC_BITS (SUM_FRAC_BITS)
        ) u_div (
            .clk   (clk),
            .adv   (adv),
            .sum   (sum_w[c]),
            .count (sample_count_reg),
            .quot  (quot),
            .flags (div_flags)
        );

        apgq_sqrt u_sqrt (
            .clk      (clk),
            .adv      (adv),
            .avg      (quot),
            .flags_in (div_flags),
            .root     (root),
            .flags    (root_flags)
        );

        apgq_scale u_scale (
            .clk       (clk),
            .adv       (adv),
            .root      (root),
            .flags_in  (root_flags),
            .chan_byte (byte_w[c])
        );
    end

    // Output register and skid: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_full_reg    <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
                skid_full_reg <= 1'b0;
        end
        else if (leaving)
        begin
            if (result_valid_reg && !take)
                skid_full_reg <= 1'b1;
            result_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
            begin
                result_byte_reg <= skid_byte_reg;
                result_eof_reg  <= skid_eof_reg;
            end
        end
        else if (leaving)
        begin
            if (result_valid_reg && !take)
            begin
                skid_byte_reg <= byte_w;
                skid_eof_reg  <= eof_reg[NUM_STAGES-1];
            end
            else
            begin
                result_byte_reg <= byte_w;
                result_eof_reg  <= eof_reg[NUM_STAGES-1];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign red_byte     = result_byte_reg[0];
    assign green_byte   = result_byte_reg[1];
    assign blue_byte    = result_byte_reg[2];
    assign frame_done   = result_eof_reg;

endmodule

[bench/tb_top.sv]
// Testbench for accumulated_pixel_gamma_quantizer_unit: pixel words with checked results.
// Uses apgq_pkg for widths and the gamma scale. It runs idle, stall and back-pressure phases.
`timescale 1ns / 1ps

module tb_top;

    localparam int SUM_W       = apgq_pkg::SUM_W;
    localparam int COUNT_W     = apgq_pkg::COUNT_W;
    localparam int AVG_W       = apgq_pkg::AVG_W;
    localparam int ROOT_W      = apgq_pkg::ROOT_W;
    localparam int BYTE_W      = apgq_pkg::BYTE_W;
    localparam int NUM_STAGES  = apgq_pkg::NUM_STAGES;
    localparam logic [15:0] GAMMA_SCALE = apgq_pkg::GAMMA_SCALE;

    localparam int SUM_FRAC = apgq_pkg::SUM_FRAC_BITS_DEF;
    localparam int LATENCY  = NUM_STAGES + 5;
    localparam int HOLD_CYCLES = 400;

    // One tonemapped pixel as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              done;
    } rgb_word_t;

    // Predicts tonemapped pixels and checks what comes out
    class tonemap_scoreboard;
        rgb_word_t         expected_q[$];
        logic [COUNT_W-1:0] count;
        int unsigned       checked;
        int unsigned       errors;

        function new();
            count   = 16'd1;
            checked = 0;
            errors  = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] v);
            count = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // floor(sqrt(v)), v never exceeds 2^32
        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 64'd0;
            for (int b = 17; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        // zero for a sum at or below zero, else average, clamp to 1.0, gamma-2 root, scale to a byte
        function logic [BYTE_W-1:0] tone_byte(logic signed [SUM_W-1:0] sum);
            logic [63:0] s;
            logic [63:0] c;
            logic [63:0] avg;
            logic [63:0] root;
            logic [63:0] prod;
            if (sum <= 0)
                return '0;
            c    = (count == 0) ? 64'd1 : 64'(count);
            s    = 64'(unsigned'(sum));
            avg  = (s << AVG_W) / (c << SUM_FRAC);
            if (avg > 64'd65536)
                avg = 64'd65536;
            root = floor_root(avg << ROOT_W);
            prod = (root * 64'(GAMMA_SCALE)) >> 24;
            if (prod > 64'd255)
                prod = 64'd255;
            return prod[BYTE_W-1:0];
        endfunction

        function void note_pixel(logic signed [SUM_W-1:0] r, logic signed [SUM_W-1:0] g,
                                 logic signed [SUM_W-1:0] b, logic eof);
            rgb_word_t w;
            w.red   = tone_byte(r);
            w.green = tone_byte(g);
            w.blue  = tone_byte(b);
            w.done  = eof;
            expected_q.push_back(w);
        endfunction

        function void check_result(rgb_word_t got);
            rgb_word_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: r=%0d g=%0d b=%0d done=%0b",
                             got.red, got.green, got.blue, got.done);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch on word %0d", checked);
                    $display("  expected r=%0d g=%0d b=%0d done=%0b",
                             want.red, want.green, want.blue, want.done);
                    $display("  actual   r=%0d g=%0d b=%0d done=%0b",
                             got.red, got.green, got.blue, got.done);
                end
            end
        endfunction

        // anything still waiting at the end is a failure
        function int unsigned close();
            if (expected_q.size() != 0)
            begin
                if (errors < 10)
                    $display("%0d expected words never arrived", expected_q.size());
                errors += expected_q.size();
            end
            return errors;
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [COUNT_W-1:0]       cfg_data;
    logic                     pixel_valid;
    logic                     pixel_stall;
    logic signed [SUM_W-1:0]  red_sum;
    logic signed [SUM_W-1:0]  green_sum;
    logic signed [SUM_W-1:0]  blue_sum;
    logic                     end_of_frame;
    logic                     result_valid;
    logic                     result_stall;
    logic [BYTE_W-1:0]        red_byte;
    logic [BYTE_W-1:0]        green_byte;
    logic [BYTE_W-1:0]        blue_byte;
    logic                     frame_done;

    tonemap_scoreboard sb;
    int unsigned send_pct;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned settings_done;

    accumulated_pixel_gamma_quantizer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .red_sum      (red_sum),
        .green_sum    (green_sum),
        .blue_sum     (blue_sum),
        .end_of_frame (end_of_frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .red_byte     (red_byte),
        .green_byte   (green_byte),
        .blue_byte    (blue_byte),
        .frame_done   (frame_done)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: random stalls, forced high during a hold-off
    always @(posedge clk)
    begin
        result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    // watch all three channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_count(cfg_data);
            if (pixel_valid && !pixel_stall)
                sb.note_pixel(red_sum, green_sum, blue_sum, end_of_frame);
            if (result_valid && !result_stall)
                sb.check_result('{red_byte, green_byte, blue_byte, frame_done});
        end
    end

    // offer one pixel word, after a random gap, and hold it until taken
    task automatic send_pixel(input logic signed [SUM_W-1:0] r,
                              input logic signed [SUM_W-1:0] g,
                              input logic signed [SUM_W-1:0] b, input logic eof);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_pct)
            gap++;
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid  <= 1'b1;
        red_sum      <= r;
        green_sum    <= g;
        blue_sum     <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (pixel_stall);
    endtask

    // stop sending and let every expected word come out
    task automatic drain();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // sample count write, only with the pipeline empty
    task automatic write_count(input logic [COUNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // mostly sums that land inside [0, 1] after averaging, plus noise and edges
    function automatic logic signed [SUM_W-1:0] pick_sum();
        logic [63:0] span;
        logic [63:0] wide;
        logic [31:0] raw;
        int unsigned sel;
        span = ((sb.count == 0) ? 64'd1 : 64'(sb.count)) << SUM_FRAC;
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            wide = {$urandom, $urandom};
            return 32'(wide % (span + 1));
        end
        else if (sel < 70)
            return $urandom;
        else if (sel < 80)
        begin
            raw = $urandom;
            raw[31] = 1'b1;
            return raw;
        end
        else if (sel < 90)
        begin
            wide = span + 64'($urandom_range(32)) - 64'd16;
            if (wide > 64'h7FFF_FFFF)
                wide = 64'h7FFF_FFFF;
            return 32'(wide);
        end
        return 32'($urandom_range(255));
    endfunction

    task automatic random_phase(input logic [COUNT_W-1:0] cnt, input int unsigned spct,
                                input int unsigned rpct, input int unsigned n,
                                input bit squeeze);
        write_count(cnt);
        send_pct  = spct;
        stall_pct <= rpct;
        if (squeeze)
            hold_left <= HOLD_CYCLES;
        repeat (n)
            send_pixel(pick_sum(), pick_sum(), pick_sum(), ($urandom_range(7) == 0));
    endtask

    // main sequence
    initial
    begin
        sb = new();
        send_pct      = 0;
        settings_done = 0;
        stall_pct    <= 0;
        hold_left    <= 0;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        pixel_valid  <= 1'b0;
        red_sum      <= '0;
        green_sum    <= '0;
        blue_sum     <= '0;
        end_of_frame <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of one: zero, smallest step, just under and at 1.0, extremes
        send_pixel(32'sh0000_0000, 32'sh0000_0001, 32'sh0000_FFFF, 1'b0);
        send_pixel(32'sh0001_0000, 32'sh0001_0001, 32'sh7FFF_FFFF, 1'b1);
        send_pixel(32'sh8000_0000, 32'shFFFF_FFFF, 32'sh8000_0001, 1'b0);
        send_pixel(32'sh0000_4000, 32'sh0000_8000, 32'sh0000_0100, 1'b0);
        send_pixel(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFE, 1'b1);
        send_pixel(32'sh0000_0002, 32'sh0000_00FF, 32'sh0000_C000, 1'b0);

        // zero count behaves as one
        write_count(16'd0);
        send_pixel(32'sh0001_0000, 32'sh0000_FFFF, 32'sh0000_0001, 1'b1);
        send_pixel(32'sh0000_8000, 32'sh7FFF_FFFF, 32'sh8000_0001, 1'b0);
        send_pixel(32'sh0000_0000, 32'sh0000_4000, 32'shFFFF_0000, 1'b0);

        // largest count: only big sums get anywhere
        write_count(16'hFFFF);
        send_pixel(32'sh7FFF_FFFF, 32'sh7FFF_8000, 32'sh0001_0000, 1'b1);
        send_pixel(32'shFFFF_0000, 32'sh3FFF_C000, 32'sh0000_FFFF, 1'b0);
        send_pixel(32'sh7FFE_FFFF, 32'sh0000_0001, 32'sh8000_0000, 1'b1);

        // random phases: settings, idle and stall mixes, one squeeze
        random_phase(16'd1,     0,  0,  200, 1'b0);
        random_phase(16'd0,     75, 0,  200, 1'b0);
        random_phase(16'hFFFF,  0,  75, 200, 1'b0);
        random_phase(16'($urandom_range(65535)), 6, 6, 200, 1'b0);
        random_phase(16'd3,     0,  0,  150, 1'b1);
        random_phase(16'd255,   6,  6,  200, 1'b0);
        random_phase(16'($urandom_range(16)), 0, 0, 150, 1'b0);

        drain();
        repeat (LATENCY) @(posedge clk);

        $display("tonemap run: %0d pixel words checked over %0d sample-count writes,",
                 sb.checked, settings_done);
        $display("with sender gaps, receiver stalls and a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (sb.close() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d failures", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #(2_000_000);
        $display("run limit reached with %0d words outstanding", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
